@@ hw/rtl/i2c_byte_master_macros.svh @@
// Assertion helpers for the I2C byte master checker.
// Both sample on the rising edge of i_clk and hold off while reset is low.
`ifndef I2C_BYTE_MASTER_MACROS_SVH
`define I2C_BYTE_MASTER_MACROS_SVH

// Implication in the same cycle.
`define I2CBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle.
`define I2CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/i2cbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2cbm_pkg;

    localparam int unsigned PHASE_W           = 16;
    localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 16'd750;
    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned BIT_IDX_W         = 4;
    localparam logic [BIT_IDX_W-1:0] ACK_BIT  = 4'd8;

    localparam int unsigned QUEUE_DEPTH       = 2;
    localparam int unsigned QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_STOP    = 3'd1,
        OP_WRITE   = 3'd2,
        OP_RD_ACK  = 3'd3,
        OP_RD_NACK = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        PH_SETUP = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } t_phase;

    // One tick after classification: cmd_ok is set only for a known opcode.
    typedef struct packed {
        logic              cmd_ok;
        t_opcode           opcode;
        logic [BYTE_W-1:0] write_data;
        logic              sda_sample;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_enable;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] read_data;
        logic              ack_ok;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/i2cbm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2cbm_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_cmd_valid,
    input  wire logic [2:0]                i_opcode,
    input  wire logic [i2cbm_pkg::BYTE_W-1:0] i_write_data,
    input  wire logic                      i_sda_sample,
    input  wire logic                      i_pop,
    output i2cbm_pkg::t_q_head             o_head
);
    import i2cbm_pkg::*;

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;
    t_item                  w_item;
    logic                   w_push;
    logic                   w_pop;

    // Classify: drop unknown opcodes to a plain tick.
    always_comb begin
        w_item.cmd_ok     = i_cmd_valid && (i_opcode <= 3'(OP_RD_NACK));
        w_item.opcode     = t_opcode'(i_opcode);
        w_item.write_data = i_write_data;
        w_item.sda_sample = i_sda_sample;
    end

    assign o_in_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        priority if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

@@ hw/rtl/i2cbm_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2cbm_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire i2cbm_pkg::t_q_head            i_head,
    output logic                               o_pop,
    input  wire logic [i2cbm_pkg::PHASE_W-1:0] i_phase_ticks,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output i2cbm_pkg::t_result                 o_result
);
    import i2cbm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_START   = 6'b000010,
        ST_STOP    = 6'b000100,
        ST_WRITE   = 6'b001000,
        ST_RD_ACK  = 6'b010000,
        ST_RD_NACK = 6'b100000
    } t_seq_state;

    t_seq_state           r_state, n_state;
    t_phase               r_phase, n_phase;
    logic [BIT_IDX_W-1:0] r_bit, n_bit;
    logic [PHASE_W-1:0]   r_cnt, n_cnt;
    logic [BYTE_W-1:0]    r_shift, n_shift;
    logic                 r_ack, n_ack;
    logic                 r_scl, n_scl;
    logic                 r_sda, n_sda;
    logic                 r_dir, n_dir;
    logic [BYTE_W-1:0]    r_last, n_last;
    logic                 r_done, n_done;
    logic                 r_out_valid;

    logic [PHASE_W-1:0]   w_plen;
    logic                 w_step;
    logic                 w_enter;
    logic                 w_byte_cmd;
    logic                 w_is_read;
    logic                 w_is_write;
    logic                 w_ack_bit;
    t_seq_state           w_cmd_state;
    t_item                w_it;

    assign w_it       = i_head.item;
    assign w_plen     = (i_phase_ticks == '0) ? PHASE_W'(1) : i_phase_ticks;
    assign w_step     = i_head.valid && (!r_out_valid || i_out_ready);
    assign o_pop      = w_step;
    assign w_is_write = (r_state == ST_WRITE);
    assign w_is_read  = (r_state == ST_RD_ACK) || (r_state == ST_RD_NACK);
    assign w_byte_cmd = w_is_write || w_is_read;
    assign w_ack_bit  = (r_bit == ACK_BIT);

    always_comb begin
        unique case (w_it.opcode)
            OP_START:   w_cmd_state = ST_START;
            OP_STOP:    w_cmd_state = ST_STOP;
            OP_WRITE:   w_cmd_state = ST_WRITE;
            OP_RD_ACK:  w_cmd_state = ST_RD_ACK;
            OP_RD_NACK: w_cmd_state = ST_RD_NACK;
            default:    w_cmd_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_dir   = r_dir;
        n_last  = r_last;
        n_done  = 1'b0;
        w_enter = 1'b0;

        if (r_state != ST_IDLE) begin
            if (r_cnt >= w_plen) begin
                n_cnt = PHASE_W'(1);
                // Sample SDA at the end of the SCL-high phase.
                if (w_byte_cmd && r_phase == PH_HIGH) begin
                    if (!w_ack_bit && w_is_read) begin
                        n_shift = {r_shift[BYTE_W-2:0], w_it.sda_sample};
                    end
                    if (w_ack_bit && w_is_write) begin
                        n_ack = ~w_it.sda_sample;
                    end
                end
                if (w_byte_cmd && r_phase == PH_LOW && !w_ack_bit && w_is_write) begin
                    n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                end
                unique case (r_phase)
                    PH_SETUP: begin
                        n_phase = PH_HIGH;
                        w_enter = 1'b1;
                    end
                    PH_HIGH: begin
                        n_phase = PH_LOW;
                        w_enter = 1'b1;
                    end
                    default: begin
                        n_phase = PH_SETUP;
                        if (w_byte_cmd && !w_ack_bit) begin
                            n_bit   = r_bit + 4'd1;
                            w_enter = 1'b1;
                        end else begin
                            if (w_is_write) begin
                                n_dir = 1'b1;
                                n_sda = 1'b1;
                            end
                            if (w_is_read) begin
                                n_last = r_shift;
                            end
                            n_state = ST_IDLE;
                            n_bit   = '0;
                            n_done  = 1'b1;
                        end
                    end
                endcase
            end else begin
                n_cnt = r_cnt + PHASE_W'(1);
            end
        end else if (w_it.cmd_ok) begin
            n_state = w_cmd_state;
            n_phase = PH_SETUP;
            n_bit   = '0;
            n_cnt   = PHASE_W'(1);
            n_shift = (w_cmd_state == ST_WRITE) ? w_it.write_data : '0;
            w_enter = 1'b1;
        end

        // Drive the pin levels of the phase just entered.
        if (w_enter) begin
            unique case (n_state)
                ST_START: begin
                    n_dir = 1'b1;
                    n_scl = (n_phase != PH_LOW);
                    n_sda = (n_phase == PH_SETUP);
                end
                ST_STOP: begin
                    n_dir = 1'b1;
                    if (n_phase != PH_SETUP) begin
                        n_scl = 1'b1;
                    end
                    n_sda = (n_phase == PH_LOW);
                end
                default: begin
                    n_scl = (n_phase == PH_HIGH);
                    if (n_phase == PH_SETUP) begin
                        if (n_bit != ACK_BIT) begin
                            if (n_state == ST_WRITE) begin
                                n_dir = 1'b1;
                                n_sda = n_shift[BYTE_W-1];
                            end else begin
                                n_dir = 1'b0;
                                n_sda = 1'b1;
                            end
                        end else begin
                            if (n_state == ST_WRITE) begin
                                n_dir = 1'b0;
                                n_sda = 1'b1;
                            end else begin
                                n_dir = 1'b1;
                                n_sda = (n_state == ST_RD_NACK);
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_SETUP;
            r_bit       <= '0;
            r_cnt       <= '0;
            r_shift     <= '0;
            r_ack       <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_dir       <= 1'b1;
            r_last      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_state <= n_state;
                r_phase <= n_phase;
                r_bit   <= n_bit;
                r_cnt   <= n_cnt;
                r_shift <= n_shift;
                r_ack   <= n_ack;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_dir   <= n_dir;
                r_last  <= n_last;
                r_done  <= n_done;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_result.scl_level   = r_scl;
    assign o_result.sda_level   = r_sda;
    assign o_result.sda_enable  = r_dir;
    assign o_result.busy        = (r_state != ST_IDLE);
    assign o_result.done        = r_done;
    assign o_result.read_data   = r_last;
    assign o_result.ack_ok      = r_ack;

endmodule

`default_nettype wire

@@ hw/rtl/i2c_byte_master.sv @@
// Channel | Direction | Handshake                  | Beat contents
// in      | input     | i_in_valid / o_in_ready    | i_cmd_valid, i_opcode, i_write_data,
//         |           |                            | i_sda_sample
// out     | output    | o_out_valid / i_out_ready  | o_scl_level, o_sda_level, o_sda_enable,
//         |           |                            | o_busy_res, o_done_res, o_read_data, o_ack_ok
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (phase_ticks)
//
// One input beat per cycle while o_in_ready is high, one output beat per input beat;
// beats pass through the two-entry front queue and the engine's state/output register.
// The engine takes one queued tick per cycle when its output slot is empty or being taken.
// Synchronous active-low reset clears the queue and drives SCL/SDA to 1 with SDA enabled.
// An output stall backs up into the queue; o_in_ready drops once both entries are full.
`timescale 1ns / 1ps
`default_nettype none

module i2c_byte_master (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_cmd_valid,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [7:0]  i_write_data,
    input  wire logic        i_sda_sample,
    // Output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_scl_level,
    output logic             o_sda_level,
    output logic             o_sda_enable,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [7:0]       o_read_data,
    output logic             o_ack_ok,
    // Configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    import i2cbm_pkg::*;

    logic [PHASE_W-1:0] r_phase_ticks;
    t_q_head            w_head;
    logic               w_pop;
    t_result            w_result;

    // Config writes must come only while idle; not enforced, they are accepted every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (i_cfg_valid) begin
            r_phase_ticks <= i_cfg_data;
        end
    end

    // Front: classify each tick and park it in the queue.
    i2cbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd_valid  (i_cmd_valid),
        .i_opcode     (i_opcode),
        .i_write_data (i_write_data),
        .i_sda_sample (i_sda_sample),
        .i_pop        (w_pop),
        .o_head       (w_head)
    );

    // Back: run the bit sequencer one tick per popped item.
    i2cbm_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_phase_ticks (r_phase_ticks),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result      (w_result)
    );

    assign o_scl_level  = w_result.scl_level;
    assign o_sda_level  = w_result.sda_level;
    assign o_sda_enable = w_result.sda_enable;
    assign o_busy_res   = w_result.busy;
    assign o_done_res   = w_result.done;
    assign o_read_data  = w_result.read_data;
    assign o_ack_ok     = w_result.ack_ok;

endmodule

`default_nettype wire

@@ hw/rtl/i2cbm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_byte_master_macros.svh"

module i2cbm_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        o_scl_level,
    input  wire logic        o_sda_level,
    input  wire logic        o_sda_enable,
    input  wire logic        o_busy_res,
    input  wire logic        o_done_res,
    input  wire logic [7:0]  o_read_data
);

    // A completing beat has already dropped busy.
    `I2CBM_ASSERT_NOW(a_done_not_busy, o_out_valid && o_done_res, !o_busy_res, "done while busy")

    // Released SDA always carries a high level.
    `I2CBM_ASSERT_NOW(a_release_high, o_out_valid && !o_sda_enable, o_sda_level, "released SDA low")

    // A stalled output beat holds.
    `I2CBM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_scl_level) && $stable(o_read_data) && $stable(o_done_res),
        "output beat changed under stall")

endmodule

bind i2c_byte_master i2cbm_checker u_i2cbm_checker (.*);

`default_nettype wire

@@ tb/i2c_byte_master_test.sv @@
`timescale 1ns / 1ps

module i2c_byte_master_test;
    import i2cbm_pkg::*;

    // Sequencer state of the bus model; values follow the opcode order plus one.
    typedef enum logic [2:0] {
        SEQ_IDLE    = 3'd0,
        SEQ_START   = 3'd1,
        SEQ_STOP    = 3'd2,
        SEQ_WRITE   = 3'd3,
        SEQ_RD_ACK  = 3'd4,
        SEQ_RD_NACK = 3'd5
    } t_seq;

    // One clock tick of the timing base as offered on the input channel.
    typedef struct {
        logic       cmd_v;
        logic [2:0] op;
        logic [7:0] wd;
        logic       sda;
    } t_bus_tick;

    localparam int HOLD_CYCLES  = 300;
    localparam int BYTE_PHASES  = (ACK_BIT + 1) * 3;
    localparam int SHORT_PHASES = 3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_cmd_valid = 1'b0;
    logic [2:0]  in_opcode = OP_START;
    logic [7:0]  in_write_data = 8'h00;
    logic        in_sda_sample = 1'b1;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data = 16'h0000;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_scl_level;
    logic        o_sda_level;
    logic        o_sda_enable;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_read_data;
    logic        o_ack_ok;
    logic        o_cfg_ready;

    always #2 i_clk = ~i_clk;

    i2c_byte_master i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd_valid  (in_cmd_valid),
        .i_opcode     (in_opcode),
        .i_write_data (in_write_data),
        .i_sda_sample (in_sda_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_scl_level  (o_scl_level),
        .o_sda_level  (o_sda_level),
        .o_sda_enable (o_sda_enable),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_read_data  (o_read_data),
        .o_ack_ok     (o_ack_ok),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------
    // Bus model: tracks the master's sequencer tick by tick and produces
    // the pin levels and status the block must show for every beat.
    // ------------------------------------------------------------------
    logic [15:0] m_phase_len = PHASE_TICKS_RESET;
    t_seq        m_seq = SEQ_IDLE;
    t_phase      m_phase = PH_SETUP;
    logic [15:0] m_tick_cnt = 16'd0;
    logic [3:0]  m_bit = 4'd0;
    logic [7:0]  m_shift = 8'h00;
    logic        m_ack = 1'b0;
    logic        m_scl = 1'b1;
    logic        m_sda = 1'b1;
    logic        m_sda_oe = 1'b1;
    logic [7:0]  m_rd_byte = 8'h00;

    t_result     expected_levels[$];
    t_bus_tick   pending_ticks[$];

    int unsigned mismatches = 0;
    int unsigned beats_checked = 0;
    int unsigned cmds_started = 0;
    int unsigned cmds_done = 0;
    int unsigned settings_used = 0;

    // Drive the levels of the phase just entered.
    function automatic void enter_levels();
        case (m_seq)
            SEQ_START: begin
                m_sda_oe = 1'b1;
                m_scl    = (m_phase != PH_LOW);
                m_sda    = (m_phase == PH_SETUP);
            end
            SEQ_STOP: begin
                // SCL keeps its level through the setup phase of a stop.
                m_sda_oe = 1'b1;
                if (m_phase != PH_SETUP) m_scl = 1'b1;
                m_sda = (m_phase == PH_LOW);
            end
            default: begin
                m_scl = (m_phase == PH_HIGH);
                if (m_phase == PH_SETUP) begin
                    if (m_bit < ACK_BIT) begin
                        if (m_seq == SEQ_WRITE) begin
                            m_sda_oe = 1'b1;
                            m_sda    = m_shift[7];
                        end else begin
                            m_sda_oe = 1'b0;
                            m_sda    = 1'b1;
                        end
                    end else if (m_seq == SEQ_WRITE) begin
                        // release SDA so the slave can acknowledge
                        m_sda_oe = 1'b0;
                        m_sda    = 1'b1;
                    end else begin
                        m_sda_oe = 1'b1;
                        m_sda    = (m_seq == SEQ_RD_NACK);
                    end
                end
            end
        endcase
    endfunction

    // Close the current phase; return 1 when the command completes.
    function automatic logic close_phase(input logic sda);
        logic byte_cmd;
        logic rd;
        byte_cmd = (m_seq == SEQ_WRITE) || (m_seq == SEQ_RD_ACK) || (m_seq == SEQ_RD_NACK);
        rd       = (m_seq == SEQ_RD_ACK) || (m_seq == SEQ_RD_NACK);
        if (byte_cmd && m_phase == PH_HIGH) begin
            if (m_bit < ACK_BIT && rd) m_shift = {m_shift[6:0], sda};
            if (m_bit == ACK_BIT && m_seq == SEQ_WRITE) m_ack = ~sda;
        end
        if (byte_cmd && m_phase == PH_LOW && m_bit < ACK_BIT && m_seq == SEQ_WRITE)
            m_shift = {m_shift[6:0], 1'b0};
        if (m_phase == PH_LOW) begin
            m_phase = PH_SETUP;
            if (byte_cmd && m_bit < ACK_BIT) begin
                m_bit = m_bit + 4'd1;
            end else begin
                if (m_seq == SEQ_WRITE) begin
                    m_sda_oe = 1'b1;
                    m_sda    = 1'b1;
                end else if (rd) begin
                    m_rd_byte = m_shift;
                end
                m_seq = SEQ_IDLE;
                m_bit = 4'd0;
                return 1'b1;
            end
        end else begin
            m_phase = t_phase'(m_phase + 2'd1);
        end
        enter_levels();
        return 1'b0;
    endfunction

    // Advance the model by one tick and return the levels it shows.
    function automatic t_result predict_bus_levels(input t_bus_tick t);
        t_result     r;
        logic [15:0] plen;
        logic        done;
        plen = (m_phase_len == 16'd0) ? 16'd1 : m_phase_len;
        done = 1'b0;
        if (m_seq != SEQ_IDLE) begin
            if (m_tick_cnt >= plen) begin
                m_tick_cnt = 16'd1;
                done = close_phase(t.sda);
            end else begin
                m_tick_cnt = m_tick_cnt + 16'd1;
            end
        end else if (t.cmd_v && t.op <= OP_RD_NACK) begin
            case (t.op)
                OP_START: m_seq = SEQ_START;
                OP_STOP:  m_seq = SEQ_STOP;
                OP_WRITE: m_seq = SEQ_WRITE;
                OP_RD_ACK: m_seq = SEQ_RD_ACK;
                default:  m_seq = SEQ_RD_NACK;
            endcase
            m_phase    = PH_SETUP;
            m_bit      = 4'd0;
            m_tick_cnt = 16'd1;
            m_shift    = (m_seq == SEQ_WRITE) ? t.wd : 8'h00;
            cmds_started++;
            enter_levels();
        end
        if (done) cmds_done++;
        r.scl_level  = m_scl;
        r.sda_level  = m_sda;
        r.sda_enable = m_sda_oe;
        r.busy       = (m_seq != SEQ_IDLE);
        r.done       = done;
        r.read_data  = m_rd_byte;
        r.ack_ok     = m_ack;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted input beat, check every accepted
    // output beat against the oldest prediction, track config writes.
    // ------------------------------------------------------------------
    logic in_taken = 1'b0;
    t_bus_tick cur_tick;

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        logic    bad;
        if (i_rst_n) begin
            if (cfg_valid && o_cfg_ready) m_phase_len = cfg_data;
            if (in_valid && o_in_ready) begin
                cur_tick.cmd_v = in_cmd_valid;
                cur_tick.op    = in_opcode;
                cur_tick.wd    = in_write_data;
                cur_tick.sda   = in_sda_sample;
                expected_levels.push_back(predict_bus_levels(cur_tick));
            end
            if (o_out_valid && out_ready) begin
                got.scl_level  = o_scl_level;
                got.sda_level  = o_sda_level;
                got.sda_enable = o_sda_enable;
                got.busy       = o_busy_res;
                got.done       = o_done_res;
                got.read_data  = o_read_data;
                got.ack_ok     = o_ack_ok;
                if (expected_levels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: output beat with no prediction pending", $realtime);
                end else begin
                    want = expected_levels.pop_front();
                    bad = (got.scl_level !== want.scl_level)
                       || (got.sda_level !== want.sda_level)
                       || (got.sda_enable !== want.sda_enable)
                       || (got.busy !== want.busy)
                       || (got.done !== want.done)
                       || (got.read_data !== want.read_data)
                       || (got.ack_ok !== want.ack_ok);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: beat %0d exp scl=%b sda=%b oe=%b busy=%b done=%b",
                                      " rd=%h ack=%b / got scl=%b sda=%b oe=%b busy=%b",
                                      " done=%b rd=%h ack=%b"},
                                     $realtime, beats_checked,
                                     want.scl_level, want.sda_level, want.sda_enable,
                                     want.busy, want.done, want.read_data, want.ack_ok,
                                     got.scl_level, got.sda_level, got.sda_enable,
                                     got.busy, got.done, got.read_data, got.ack_ok);
                    end
                    beats_checked++;
                end
            end
        end
        in_taken <= in_valid && o_in_ready;
    end

    // ------------------------------------------------------------------
    // Driver: present queued ticks at the falling edge, hold each beat
    // until it is taken, and idle at the current sender rate.
    // ------------------------------------------------------------------
    int send_idle = 0;
    int recv_stall = 0;

    always @(negedge i_clk) begin : driver
        t_bus_tick nxt;
        if (i_rst_n && (!in_valid || in_taken)) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle) begin
                nxt = pending_ticks.pop_front();
                in_cmd_valid  <= nxt.cmd_v;
                in_opcode     <= nxt.op;
                in_write_data <= nxt.wd;
                in_sda_sample <= nxt.sda;
                in_valid      <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request that lets
    // the block fill up and drop its input ready.
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    always @(negedge i_clk) begin : receiver
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
            out_ready    <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation. The generator keeps a rough count of how long
    // the current command keeps the master busy, so that most commands
    // land on a free tick and form real start / byte / stop frames.
    // ------------------------------------------------------------------
    int   gen_plen = PHASE_TICKS_RESET;
    int   gen_busy_left = 0;
    logic gen_in_frame = 1'b0;

    function automatic int cmd_ticks(input logic [2:0] op);
        return ((op == OP_START || op == OP_STOP) ? SHORT_PHASES : BYTE_PHASES) * gen_plen;
    endfunction

    task automatic push_tick(input logic cmd_v, input logic [2:0] op, input logic [7:0] wd);
        t_bus_tick t;
        t.cmd_v = cmd_v;
        t.op    = op;
        t.wd    = wd;
        t.sda   = 1'($urandom_range(1));
        pending_ticks.push_back(t);
        if (gen_busy_left != 0) begin
            gen_busy_left--;
        end else if (cmd_v && op <= OP_RD_NACK) begin
            gen_busy_left = cmd_ticks(op);
            if (op == OP_START) gen_in_frame = 1'b1;
            if (op == OP_STOP) gen_in_frame = 1'b0;
        end
    endtask

    // Fill out the rest of the running command, the done tick included;
    // with noise set, sprinkle commands that must be ignored.
    task automatic finish_cmd(input bit noisy);
        logic [2:0] op;
        while (gen_busy_left != 0) begin
            op = 3'($urandom_range(7));
            push_tick(noisy && $urandom_range(9) == 0, op, 8'($urandom));
        end
    endtask

    task automatic run_cmd(input logic [2:0] op, input logic [7:0] wd, input bit noisy);
        push_tick(1'b1, op, wd);
        finish_cmd(noisy);
    endtask

    task automatic random_traffic(input int n_ticks);
        int         r;
        logic [2:0] op;
        for (int k = 0; k < n_ticks; k++) begin
            if (gen_busy_left == 0) begin
                r = $urandom_range(99);
                if (r < 75) begin
                    // Mostly well-formed frames: open with start, then bytes, then stop.
                    r = $urandom_range(99);
                    if (!gen_in_frame) op = (r < 85) ? OP_START : 3'($urandom_range(4));
                    else if (r < 45) op = OP_WRITE;
                    else if (r < 65) op = OP_RD_ACK;
                    else if (r < 80) op = OP_RD_NACK;
                    else if (r < 90) op = OP_STOP;
                    else op = OP_START;
                    push_tick(1'b1, op, 8'($urandom));
                end else if (r < 80) begin
                    op = 3'($urandom_range(7, 5));
                    push_tick(1'b1, op, 8'($urandom));
                end else begin
                    op = 3'($urandom_range(7));
                    push_tick(1'b0, op, 8'($urandom));
                end
            end else begin
                op = 3'($urandom_range(7));
                push_tick($urandom_range(9) == 0, op, 8'($urandom));
            end
        end
        finish_cmd(1'b0);
    endtask

    // Wait until every tick is through and every prediction checked, then
    // let the pipeline settle.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || in_valid || expected_levels.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_phase_ticks(input logic [15:0] v);
        wait_drained();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        gen_plen = (v == 16'd0) ? 1 : v;
        settings_used++;
        @(posedge i_clk);
    endtask

    // Offer quiet ticks while a start or stop sits in its first long phase,
    // then drop the phase length to one: the running phase ends on the next
    // tick and the command completes three ticks after the write.
    task automatic cut_short(input int n_ticks);
        for (int k = 0; k < n_ticks; k++) push_tick(1'b0, OP_START, 8'h00);
        set_phase_ticks(16'd1);
        gen_busy_left = 3;
        finish_cmd(1'b0);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    logic [15:0] rand_plens[8] = '{16'd1, 16'd1, 16'd2, 16'd1, 16'd3, 16'd1, 16'd2, 16'd5};
    int          idle_tx[4] = '{0, 58, 0, 35};
    int          idle_rx[4] = '{0, 0, 58, 35};

    initial begin : main
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset phase length: a start that stays in its first phase, then cut short.
        push_tick(1'b1, OP_START, 8'h00);
        cut_short(40);

        // Shortest phase: every opcode and the byte extremes.
        set_phase_ticks(16'd1);
        run_cmd(OP_START, 8'h00, 1'b1);
        run_cmd(OP_WRITE, 8'h00, 1'b0);
        run_cmd(OP_WRITE, 8'hFF, 1'b0);
        run_cmd(OP_WRITE, 8'hA5, 1'b1);
        run_cmd(OP_RD_ACK, 8'hFF, 1'b0);
        run_cmd(OP_RD_NACK, 8'h00, 1'b1);
        run_cmd(OP_START, 8'h00, 1'b0);
        run_cmd(OP_RD_ACK, 8'h00, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0);
        // Unknown opcodes and a tick without a command: nothing starts.
        push_tick(1'b1, 3'd5, 8'h11);
        push_tick(1'b1, 3'd6, 8'h22);
        push_tick(1'b1, 3'd7, 8'h33);
        push_tick(1'b0, OP_WRITE, 8'h44);
        // A command on the completion tick is dropped.
        push_tick(1'b1, OP_START, 8'h00);
        while (gen_busy_left > 1) push_tick(1'b0, OP_START, 8'h00);
        push_tick(1'b1, OP_WRITE, 8'h5A);
        run_cmd(OP_WRITE, 8'h80, 1'b0);
        run_cmd(OP_WRITE, 8'h01, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b1);

        // Zero phase length behaves as one.
        set_phase_ticks(16'd0);
        run_cmd(OP_START, 8'h00, 1'b0);
        run_cmd(OP_WRITE, 8'h3C, 1'b0);
        run_cmd(OP_RD_NACK, 8'h00, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0);

        // Longest phase: a start condition held in its first phase, then cut short.
        set_phase_ticks(16'hFFFF);
        push_tick(1'b1, OP_START, 8'h00);
        cut_short(40);

        // Random frames over short phase lengths and every idling mode.
        for (int ph = 0; ph < 8; ph++) begin
            set_phase_ticks(rand_plens[ph]);
            send_idle  = idle_tx[ph % 4];
            recv_stall = idle_rx[ph % 4];
            if (ph == 0) hold_requests++;
            random_traffic(80);
        end
        wait_drained();

        $display("covered %0d beats, %0d bus commands started, %0d completed, %0d settings",
                 beats_checked, cmds_started, cmds_done, settings_used);
        $display("phase lengths 750, 0, 1 and 65535 plus small ones; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog well past the slowest correct run.
    initial begin : watchdog
        #10_000_000;
        $display("watchdog expired with %0d predictions outstanding", expected_levels.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
